@@ rtl/tdpt_pkg.sv @@
// package for the trial division prime test: shared constants
`timescale 1ns / 1ps

package tdpt_pkg;

   localparam int NUMBER_WIDTH_DEFAULT = 16;
   localparam int FIRST_DIVISOR        = 2;

endpackage

@@ rtl/trial_division_prime_test.sv @@
// trial division prime test: one number in, one prime flag out, bit-serial remainder
`timescale 1ns / 1ps
//
// Usage: drive req_number and raise start while busy is low; that beat is taken.
// busy stays high while the number is tested. The result appears on rsp_tested_number
// and rsp_is_prime for exactly one cycle, marked by rsp_valid, in the first cycle that busy
// is low again; the receiver cannot stall it, and a new start may be given in that same cycle.
// Divisors d = 2, 3, ... are tried while d*d <= n; d*d is kept up to date by adding
// 2d+1 per step. Each remainder n mod d is formed by a restoring divider that takes
// one bit of n per cycle. Numbers below 2 are answered at once as not prime; others
// end as not prime at the first divisor that divides n, or as prime once d*d exceeds
// n, after floor(sqrt(n)) - 1 divisors.
// One number is tested at a time.
// Reset (synchronous, active high) returns the block to idle with no result pending;
// a test in progress is dropped.
//
module trial_division_prime_test #(
   parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   output logic                    rsp_valid,
   output logic [NUMBER_WIDTH-1:0] rsp_tested_number,
   output logic                    rsp_is_prime
);

   localparam int CW = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;
   localparam logic [CW-1:0] LAST_BIT = CW'(NUMBER_WIDTH - 1);
   localparam logic [NUMBER_WIDTH-1:0] D_INIT = NUMBER_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
   localparam logic [NUMBER_WIDTH:0] SQ_INIT =
      (NUMBER_WIDTH + 1)'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE
   } state_type;

   state_type               state_ff;
   logic [NUMBER_WIDTH-1:0] n_ff;
   logic [NUMBER_WIDTH-1:0] d_ff;
   logic [NUMBER_WIDTH:0]   sq_ff;
   logic [NUMBER_WIDTH-1:0] rem_ff;
   logic [NUMBER_WIDTH-1:0] shift_ff;
   logic [CW-1:0]           cnt_ff;
   logic                    rsp_valid_ff;
   logic [NUMBER_WIDTH-1:0] rsp_number_ff;
   logic                    rsp_prime_ff;

   logic [NUMBER_WIDTH:0]   trial_rem;
   logic [NUMBER_WIDTH:0]   d_ext;
   logic [NUMBER_WIDTH-1:0] rem_in;
   logic [NUMBER_WIDTH:0]   sq_in;

   // one restoring division step, and the square of the next divisor
   always_comb begin
      d_ext     = {1'b0, d_ff};
      trial_rem = {rem_ff, shift_ff[NUMBER_WIDTH-1]};
      if (trial_rem >= d_ext) begin
         rem_in = NUMBER_WIDTH'(trial_rem - d_ext);
      end else begin
         rem_in = trial_rem[NUMBER_WIDTH-1:0];
      end
      sq_in = sq_ff + {d_ff, 1'b1};
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  n_ff  <= req_number;
                  d_ff  <= D_INIT;
                  sq_ff <= SQ_INIT;
                  if (req_number < D_INIT) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_number_ff <= req_number;
                     rsp_prime_ff  <= 1'b0;
                  end else begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if (sq_ff > {1'b0, n_ff}) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_number_ff <= n_ff;
                  rsp_prime_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else begin
                  rem_ff   <= '0;
                  shift_ff <= n_ff;
                  cnt_ff   <= LAST_BIT;
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               rem_ff   <= rem_in;
               shift_ff <= {shift_ff[NUMBER_WIDTH-2:0], 1'b0};
               cnt_ff   <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  if (rem_in == '0) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_number_ff <= n_ff;
                     rsp_prime_ff  <= 1'b0;
                     state_ff      <= ST_IDLE;
                  end else begin
                     d_ff     <= d_ff + 1'b1;
                     sq_ff    <= sq_in;
                     state_ff <= ST_CHECK;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tested_number = rsp_number_ff;
   assign rsp_is_prime      = rsp_prime_ff;

   // result beat only once the block is idle again
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result shown while busy");

   // a prime flag never goes with zero or one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_prime) |-> (rsp_tested_number >= D_INIT))
      else $error("zero or one flagged prime");

   // an accepted number either starts a test or answers at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted number lost");

   // divisor never drops below the first candidate and its square never exceeds n while dividing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (d_ff >= D_INIT && sq_ff <= {1'b0, n_ff}))
      else $error("divisor out of range");

endmodule
